// ===== sv/rrc_pkg.sv =====
// shared types and constants of the ramped ratio compressor
package rrc_pkg;

  localparam int SampleW = 24;
  localparam int RatioW  = 23;
  localparam int LenW    = 16;
  localparam int GainW   = 16;
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 3;

  // serial divider: 24 quotient bits, two per cycle
  localparam int DivQuoW     = 24;
  localparam int DivRemW     = 23;
  localparam int DivBitsPerCycle = 2;
  localparam int DivCycles   = DivQuoW / DivBitsPerCycle;
  localparam int DivCntW     = $clog2(DivCycles);

  localparam logic [SampleW-1:0] FullQ23  = 24'd8388608;
  localparam logic [SampleW-1:0] OutMax   = 24'd8388607;
  localparam logic [RatioW-1:0]  UnityQ16 = 23'd65536;
  localparam logic [RatioW-1:0]  MaxRatio = 23'd6553600;

  localparam logic [CfgW-1:0]    ThrReset  = 24'd8388608;
  localparam logic [RatioW-1:0]  RatReset  = 23'd65536;
  localparam logic [LenW-1:0]    AttReset  = 16'd2205;
  localparam logic [LenW-1:0]    RelReset  = 16'd3087;
  localparam logic [GainW-1:0]   GainReset = 16'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_RATIO     = 3'd1,
    CFG_ATTACK    = 3'd2,
    CFG_RELEASE   = 3'd3,
    CFG_MAKEUP    = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE_LD,
    ST_RATE_DIV,
    ST_AMT,
    ST_FACT_LD,
    ST_FACT_DIV,
    ST_FACTOR,
    ST_MUL1,
    ST_MID,
    ST_MUL2,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic rate_ld;
    logic amt_upd;
    logic fact_ld;
    logic factor_ld;
    logic mul1;
    logic mid_ld;
    logic mul2;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

// ===== sv/rrc_div.sv =====
// restoring divider, two quotient bits per cycle
module rrc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [rrc_pkg::DivRemW-1:0]  rem_init_i,
  input  logic [rrc_pkg::DivQuoW-1:0]  dvd_init_i,
  input  logic [rrc_pkg::DivRemW-1:0]  divisor_i,
  output logic                         busy_o,
  output logic [rrc_pkg::DivQuoW-1:0]  quo_o
);

  logic                        busy_q, busy_d;
  logic [rrc_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [rrc_pkg::DivRemW-1:0] rem_q, rem_d;
  logic [rrc_pkg::DivQuoW-1:0] dvd_q, dvd_d;
  logic [rrc_pkg::DivRemW-1:0] dsr_q, dsr_d;

  logic [rrc_pkg::DivRemW:0]   s0, s1, dsr_x;
  logic [rrc_pkg::DivRemW-1:0] r0, r1;
  logic                        q0, q1;

  always_comb begin
    dsr_x = {1'b0, dsr_q};
    s0 = {rem_q, dvd_q[rrc_pkg::DivQuoW-1]};
    if (s0 >= dsr_x) begin
      r0 = rrc_pkg::DivRemW'(s0 - dsr_x);
      q0 = 1'b1;
    end else begin
      r0 = s0[rrc_pkg::DivRemW-1:0];
      q0 = 1'b0;
    end
    s1 = {r0, dvd_q[rrc_pkg::DivQuoW-2]};
    if (s1 >= dsr_x) begin
      r1 = rrc_pkg::DivRemW'(s1 - dsr_x);
      q1 = 1'b1;
    end else begin
      r1 = s1[rrc_pkg::DivRemW-1:0];
      q1 = 1'b0;
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (load_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = rem_init_i;
      dvd_d  = dvd_init_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = r1;
      dvd_d = {dvd_q[rrc_pkg::DivQuoW-3:0], q0, q1};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == rrc_pkg::DivCntW'(rrc_pkg::DivCycles - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = dvd_q;

endmodule

// ===== sv/rrc_dp.sv =====
// datapath: config registers, amount state, divider, multipliers, output register
module rrc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rrc_pkg::cmd_t                       cmd_i,
  output rrc_pkg::status_t                    status_o,
  input  logic                                cfg_we_i,
  input  logic [rrc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [rrc_pkg::CfgW-1:0]            cfg_data_i,
  input  logic signed [rrc_pkg::SampleW-1:0]  sample_in_i,
  input  logic                                block_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rrc_pkg::SampleW-1:0]  sample_out_o,
  output logic                                block_end_out_o,
  output logic [rrc_pkg::RatioW-1:0]          amount_out_o
);

  // configuration
  logic [rrc_pkg::CfgW-1:0]    thr_cfg_q;
  logic [rrc_pkg::RatioW-1:0]  rat_cfg_q;
  logic [rrc_pkg::LenW-1:0]    att_cfg_q, rel_cfg_q;
  logic [rrc_pkg::GainW-1:0]   gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_cfg_q <= rrc_pkg::ThrReset;
      rat_cfg_q <= rrc_pkg::RatReset;
      att_cfg_q <= rrc_pkg::AttReset;
      rel_cfg_q <= rrc_pkg::RelReset;
      gain_q    <= rrc_pkg::GainReset;
    end else if (cfg_we_i) begin
      case (rrc_pkg::cfg_idx_e'(cfg_idx_i))
        rrc_pkg::CFG_THRESHOLD: thr_cfg_q <= cfg_data_i;
        rrc_pkg::CFG_RATIO:     rat_cfg_q <= cfg_data_i[rrc_pkg::RatioW-1:0];
        rrc_pkg::CFG_ATTACK:    att_cfg_q <= cfg_data_i[rrc_pkg::LenW-1:0];
        rrc_pkg::CFG_RELEASE:   rel_cfg_q <= cfg_data_i[rrc_pkg::LenW-1:0];
        rrc_pkg::CFG_MAKEUP:    gain_q    <= cfg_data_i[rrc_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  // clamped settings
  logic [rrc_pkg::SampleW-1:0] thr;
  logic [rrc_pkg::RatioW-1:0]  rat;
  logic [rrc_pkg::LenW-1:0]    att, rel;

  always_comb begin
    thr = (thr_cfg_q > rrc_pkg::FullQ23) ? rrc_pkg::FullQ23 : thr_cfg_q;
    if (rat_cfg_q < rrc_pkg::UnityQ16) begin
      rat = rrc_pkg::UnityQ16;
    end else if (rat_cfg_q > rrc_pkg::MaxRatio) begin
      rat = rrc_pkg::MaxRatio;
    end else begin
      rat = rat_cfg_q;
    end
    att = (att_cfg_q == '0) ? rrc_pkg::LenW'(1) : att_cfg_q;
    rel = (rel_cfg_q == '0) ? rrc_pkg::LenW'(1) : rel_cfg_q;
  end

  // request capture
  logic [rrc_pkg::SampleW-1:0] raw, mag_q;
  logic                        neg_q, blk_q;

  assign raw = sample_in_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      neg_q <= raw[rrc_pkg::SampleW-1];
      mag_q <= raw[rrc_pkg::SampleW-1] ? rrc_pkg::SampleW'(24'd0 - raw) : raw;
      blk_q <= block_end_i;
    end
  end

  logic above;
  assign above = mag_q > thr;

  // shared divider
  logic                        div_load, div_busy;
  logic [rrc_pkg::DivRemW-1:0] div_rem_init, div_dsr;
  logic [rrc_pkg::DivQuoW-1:0] div_dvd_init, div_quo;
  logic [rrc_pkg::SampleW-1:0] head;
  logic [rrc_pkg::RatioW-1:0]  amt_q;

  assign head     = rrc_pkg::SampleW'(rrc_pkg::FullQ23 - thr);
  assign div_load = cmd_i.rate_ld | cmd_i.fact_ld;

  always_comb begin
    if (cmd_i.rate_ld) begin
      div_rem_init = '0;
      div_dvd_init = {1'b0, rat};
      div_dsr      = {7'b0, (above ? att : rel)};
    end else begin
      // (head << 16) / amount, top 16 quotient bits known zero
      div_rem_init = {7'b0, head[rrc_pkg::SampleW-1:8]};
      div_dvd_init = {head[7:0], 16'b0};
      div_dsr      = amt_q;
    end
  end

  rrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (div_load),
    .rem_init_i (div_rem_init),
    .dvd_init_i (div_dvd_init),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .quo_o      (div_quo)
  );

  // amount ramp with clamp
  logic [rrc_pkg::RatioW-1:0] step, amt_d;
  logic [rrc_pkg::RatioW:0]   up_sum, down_lim;

  always_comb begin
    step     = div_quo[rrc_pkg::RatioW-1:0];
    up_sum   = {1'b0, amt_q} + {1'b0, step};
    down_lim = {1'b0, rrc_pkg::UnityQ16} + {1'b0, step};
    if (above) begin
      amt_d = (up_sum > {1'b0, rat}) ? rat : up_sum[rrc_pkg::RatioW-1:0];
    end else if ({1'b0, amt_q} < down_lim) begin
      amt_d = rrc_pkg::UnityQ16;
    end else begin
      amt_d = amt_q - step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amt_q <= rrc_pkg::UnityQ16;
    end else if (cmd_i.amt_upd) begin
      amt_q <= amt_d;
    end
  end

  // gain chain
  logic [rrc_pkg::SampleW-1:0]   factor_q, mid_q;
  logic [2*rrc_pkg::SampleW-1:0] prod1_q, prod1_rnd;
  logic [rrc_pkg::SampleW+rrc_pkg::GainW-1:0] prod2_q, prod2_rnd;

  assign prod1_rnd = prod1_q + (2*rrc_pkg::SampleW)'(1 << 22);
  assign prod2_rnd = prod2_q + (rrc_pkg::SampleW + rrc_pkg::GainW)'(1 << 11);

  always_ff @(posedge clk_i) begin
    if (cmd_i.factor_ld) begin
      factor_q <= rrc_pkg::SampleW'(thr + div_quo);
    end
    if (cmd_i.mul1) begin
      prod1_q <= mag_q * factor_q;
    end
    if (cmd_i.mid_ld) begin
      mid_q <= prod1_rnd[23 +: rrc_pkg::SampleW];
    end
    if (cmd_i.mul2) begin
      prod2_q <= mid_q * gain_q;
    end
  end

  // rounding, saturation, sign
  logic [rrc_pkg::SampleW+rrc_pkg::GainW-13:0] res;
  logic [rrc_pkg::SampleW-1:0] res_sat, out_val;

  always_comb begin
    res = prod2_rnd[rrc_pkg::SampleW+rrc_pkg::GainW-1:12];
    if (neg_q) begin
      res_sat = (res > 28'(rrc_pkg::FullQ23)) ? rrc_pkg::FullQ23
                                               : res[rrc_pkg::SampleW-1:0];
      out_val = rrc_pkg::SampleW'(24'd0 - res_sat);
    end else begin
      res_sat = (res > 28'(rrc_pkg::OutMax)) ? rrc_pkg::OutMax
                                              : res[rrc_pkg::SampleW-1:0];
      out_val = res_sat;
    end
  end

  // output register
  logic                        out_valid_q;
  logic [rrc_pkg::SampleW-1:0] out_sample_q;
  logic                        out_blk_q;
  logic [rrc_pkg::RatioW-1:0]  out_amt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_sample_q <= out_val;
      out_blk_q    <= blk_q;
      out_amt_q    <= amt_q;
    end
  end

  assign status_o.div_busy = div_busy;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_sample_q;
  assign block_end_out_o = out_blk_q;
  assign amount_out_o    = out_amt_q;

endmodule

// ===== sv/rrc_ctrl.sv =====
// controller state machine sequencing one request through the datapath
module rrc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rrc_pkg::status_t status_i,
  output rrc_pkg::cmd_t    cmd_o
);

  rrc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rrc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = rrc_pkg::ST_RATE_LD;
        end
      end
      rrc_pkg::ST_RATE_LD: begin
        cmd_o.rate_ld = 1'b1;
        state_d       = rrc_pkg::ST_RATE_DIV;
      end
      rrc_pkg::ST_RATE_DIV: begin
        if (!status_i.div_busy) begin
          state_d = rrc_pkg::ST_AMT;
        end
      end
      rrc_pkg::ST_AMT: begin
        cmd_o.amt_upd = 1'b1;
        state_d       = rrc_pkg::ST_FACT_LD;
      end
      rrc_pkg::ST_FACT_LD: begin
        cmd_o.fact_ld = 1'b1;
        state_d       = rrc_pkg::ST_FACT_DIV;
      end
      rrc_pkg::ST_FACT_DIV: begin
        if (!status_i.div_busy) begin
          state_d = rrc_pkg::ST_FACTOR;
        end
      end
      rrc_pkg::ST_FACTOR: begin
        cmd_o.factor_ld = 1'b1;
        state_d         = rrc_pkg::ST_MUL1;
      end
      rrc_pkg::ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = rrc_pkg::ST_MID;
      end
      rrc_pkg::ST_MID: begin
        cmd_o.mid_ld = 1'b1;
        state_d      = rrc_pkg::ST_MUL2;
      end
      rrc_pkg::ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = rrc_pkg::ST_OUT;
      end
      rrc_pkg::ST_OUT: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = rrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rrc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ramped_ratio_compressor_top.sv =====
// top level of the ramped ratio compressor
//
// Sample compressor with a ramped compression amount. One request on the
// input channel (in_valid_i / in_ready_o) carries a Q1.23 sample and a block
// end flag; one result on the output channel (out_valid_o / out_ready_i)
// carries the compressed, gained and saturated sample, the flag and the
// compression amount after that sample.
// From input accept to output valid, a request makes two passes through
// one serial divider (ramp step, then gain factor), each pass a load,
// iterations of two quotient bits each, and done, plus the amount update,
// the factor register, two registered multiplies, the rounding register and
// the output load. One request is in flight at a time: the controller takes
// the next request only after it has loaded the last result for output.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls, the following result waits in the
// controller until the output register frees up, and no new request is taken.
// Reset restores the configuration defaults and sets the amount to 1.0.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
// and are meant to be issued while the block is idle.
module ramped_ratio_compressor_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rrc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [rrc_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [rrc_pkg::SampleW-1:0]  sample_in_i,
  input  logic                                block_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rrc_pkg::SampleW-1:0]  sample_out_o,
  output logic                                block_end_out_o,
  output logic [rrc_pkg::RatioW-1:0]          amount_out_o
);

  rrc_pkg::cmd_t    cmd;
  rrc_pkg::status_t status;

  rrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .sample_in_i     (sample_in_i),
    .block_end_i     (block_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sample_out_o    (sample_out_o),
    .block_end_out_o (block_end_out_o),
    .amount_out_o    (amount_out_o)
  );

endmodule

// ===== sv/rrc_chk.sv =====
// port-level checker for the ramped ratio compressor, bound to the top level
module rrc_chk (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rrc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [rrc_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_o,
  input  logic signed [rrc_pkg::SampleW-1:0]  sample_in_i,
  input  logic                                block_end_i,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic signed [rrc_pkg::SampleW-1:0]  sample_out_o,
  input  logic                                block_end_out_o,
  input  logic [rrc_pkg::RatioW-1:0]          amount_out_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o)
      && $stable(amount_out_o) && $stable(block_end_out_o))
    else $error("output changed while stalled");

  // one request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // a new result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work");

  // amount stays within 1.0 .. 100.0
  a_amount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> amount_out_o >= rrc_pkg::UnityQ16
      && amount_out_o <= rrc_pkg::MaxRatio)
    else $error("compression amount out of range");

endmodule

bind ramped_ratio_compressor_top rrc_chk u_rrc_chk (.*);

// ===== tb/testbench.sv =====
// testbench for ramped_ratio_compressor_top: directed cases and random traffic checked against a cycle-free predictor
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 40;
  localparam int PhaseItems = 250;
  localparam int RandomPhases = 8;

  typedef enum int {
    RUN_NOISE,
    RUN_LOUD,
    RUN_QUIET,
    RUN_EDGE
  } run_kind_e;

  typedef struct packed {
    logic [rrc_pkg::SampleW-1:0] sample;
    logic                        block_end;
  } request_t;

  typedef struct packed {
    logic signed [rrc_pkg::SampleW-1:0] sample;
    logic                               block_end;
    logic [rrc_pkg::RatioW-1:0]         amount;
  } result_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               cfg_we_i = 1'b0;
  logic [rrc_pkg::CfgIdxW-1:0]        cfg_idx_i = '0;
  logic [rrc_pkg::CfgW-1:0]           cfg_data_i = '0;
  logic                               in_valid_i = 1'b0;
  logic                               in_ready_o;
  logic signed [rrc_pkg::SampleW-1:0] sample_in_i = '0;
  logic                               block_end_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic signed [rrc_pkg::SampleW-1:0] sample_out_o;
  logic                               block_end_out_o;
  logic [rrc_pkg::RatioW-1:0]         amount_out_o;

  // register shadows and the running compression amount
  logic [rrc_pkg::CfgW-1:0]   thr_q23 = rrc_pkg::ThrReset;
  logic [rrc_pkg::RatioW-1:0] ratio_q16 = rrc_pkg::RatReset;
  logic [rrc_pkg::LenW-1:0]   attack_len = rrc_pkg::AttReset;
  logic [rrc_pkg::LenW-1:0]   release_len = rrc_pkg::RelReset;
  logic [rrc_pkg::GainW-1:0]  gain_q12 = rrc_pkg::GainReset;
  logic [rrc_pkg::RatioW-1:0] amount_q16 = rrc_pkg::UnityQ16;

  request_t pending_requests[$];
  result_t  predicted_out[$];
  request_t req;
  result_t  want;
  bit       req_taken = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       rx_mode = 0;
  int       rx_left = 0;
  int       mismatch_count = 0;
  int       cycle_count = 0;

  ramped_ratio_compressor_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_in_i    (sample_in_i),
    .block_end_i    (block_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_out_o   (sample_out_o),
    .block_end_out_o(block_end_out_o),
    .amount_out_o   (amount_out_o)
  );

  always #10 clk_i = ~clk_i;

  // advances the amount and returns the compressed sample for one request
  function automatic result_t compress_sample(logic [rrc_pkg::SampleW-1:0] raw, logic blk);
    result_t     r;
    logic        neg;
    logic [63:0] mag, thr, rat, att, rel, amt, step, factor, mid, res;
    neg = raw[rrc_pkg::SampleW-1];
    mag = neg ? (64'h1000000 - {40'd0, raw}) : {40'd0, raw};
    thr = (thr_q23 > rrc_pkg::FullQ23) ? 64'(rrc_pkg::FullQ23) : 64'(thr_q23);
    rat = 64'(ratio_q16);
    if (rat < 64'(rrc_pkg::UnityQ16)) rat = 64'(rrc_pkg::UnityQ16);
    if (rat > 64'(rrc_pkg::MaxRatio)) rat = 64'(rrc_pkg::MaxRatio);
    att = (attack_len == '0) ? 64'd1 : 64'(attack_len);
    rel = (release_len == '0) ? 64'd1 : 64'(release_len);
    amt = 64'(amount_q16);
    if (mag > thr) begin
      step = rat / att;
      amt = (amt + step > rat) ? rat : amt + step;
    end else begin
      step = rat / rel;
      amt = (amt < 64'(rrc_pkg::UnityQ16) + step) ? 64'(rrc_pkg::UnityQ16) : amt - step;
    end
    amount_q16 = amt[rrc_pkg::RatioW-1:0];
    factor = thr + (((64'(rrc_pkg::FullQ23) - thr) << 16) / 64'(amount_q16));
    mid = (mag * factor + (64'd1 << 22)) >> 23;
    res = (mid * 64'(gain_q12) + (64'd1 << 11)) >> 12;
    if (neg) begin
      if (res > 64'(rrc_pkg::FullQ23)) res = 64'(rrc_pkg::FullQ23);
      r.sample = 24'(64'h1000000 - res);
    end else begin
      if (res > 64'(rrc_pkg::OutMax)) res = 64'(rrc_pkg::OutMax);
      r.sample = res[rrc_pkg::SampleW-1:0];
    end
    r.block_end = blk;
    r.amount = amount_q16;
    return r;
  endfunction

  // picks a sample relative to the current threshold, or a random one for noise runs
  function automatic logic [rrc_pkg::SampleW-1:0] pick_sample(run_kind_e kind);
    logic [31:0] te, mag;
    logic        neg;
    te = (thr_q23 > rrc_pkg::FullQ23) ? 32'(rrc_pkg::FullQ23) : 32'(thr_q23);
    if (kind == RUN_LOUD && te == 32'(rrc_pkg::FullQ23)) kind = RUN_NOISE;
    case (kind)
      RUN_LOUD:  mag = $urandom_range(te + 1, 32'(rrc_pkg::FullQ23));
      RUN_QUIET: mag = $urandom_range(0, te);
      RUN_EDGE: begin
        mag = te + $urandom_range(0, 1);
        if (mag > 32'(rrc_pkg::FullQ23)) mag = 32'(rrc_pkg::FullQ23);
      end
      default: return rrc_pkg::SampleW'($urandom);
    endcase
    if (mag == 32'(rrc_pkg::FullQ23)) neg = 1'b1;
    else if (mag == 0) neg = 1'b0;
    else neg = 1'($urandom_range(0, 1));
    return neg ? 24'(32'h1000000 - mag) : mag[rrc_pkg::SampleW-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    if (mismatch_count < 100)
      $display("%0t ns: %s got %0h, expected %0h", $time, what, got, exp_val);
    mismatch_count++;
  endtask

  task automatic push_request(logic [rrc_pkg::SampleW-1:0] s, logic blk);
    request_t r;
    r.sample = s;
    r.block_end = blk;
    pending_requests.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid_i || predicted_out.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(rrc_pkg::cfg_idx_e idx, logic [rrc_pkg::CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rrc_pkg::CFG_THRESHOLD: thr_q23 = data;
      rrc_pkg::CFG_RATIO:     ratio_q16 = data[rrc_pkg::RatioW-1:0];
      rrc_pkg::CFG_ATTACK:    attack_len = data[rrc_pkg::LenW-1:0];
      rrc_pkg::CFG_RELEASE:   release_len = data[rrc_pkg::LenW-1:0];
      rrc_pkg::CFG_MAKEUP:    gain_q12 = data[rrc_pkg::GainW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [rrc_pkg::CfgW-1:0] thr, logic [rrc_pkg::CfgW-1:0] rat,
                           logic [rrc_pkg::CfgW-1:0] att, logic [rrc_pkg::CfgW-1:0] rel,
                           logic [rrc_pkg::CfgW-1:0] gain);
    write_reg(rrc_pkg::CFG_THRESHOLD, thr);
    write_reg(rrc_pkg::CFG_RATIO, rat);
    write_reg(rrc_pkg::CFG_ATTACK, att);
    write_reg(rrc_pkg::CFG_RELEASE, rel);
    write_reg(rrc_pkg::CFG_MAKEUP, gain);
  endtask

  function automatic logic [rrc_pkg::CfgW-1:0] pick_length();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 24'd1;
      2: return 24'd65535;
      3: return rrc_pkg::CfgW'($urandom);
      default: return rrc_pkg::CfgW'($urandom_range(1, 64));
    endcase
  endfunction

  // sender: bursts of requests with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      req_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        req = pending_requests.pop_front();
        in_valid_i <= 1'b1;
        sample_in_i <= req.sample;
        block_end_i <= req.block_end;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: always ready, coin flip, or mostly stalled
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(50, 400);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_out.size() == 0) begin
          report_mismatch("result with no request", 64'(sample_out_o), 64'd0);
        end else begin
          want = predicted_out.pop_front();
          if (sample_out_o !== want.sample)
            report_mismatch("sample_out", 64'(sample_out_o), 64'(want.sample));
          if (block_end_out_o !== want.block_end)
            report_mismatch("block_end_out", 64'(block_end_out_o), 64'(want.block_end));
          if (amount_out_o !== want.amount)
            report_mismatch("amount_out", 64'(amount_out_o), 64'(want.amount));
        end
      end
      if (in_valid_i && in_ready_o) begin
        predicted_out.push_back(compress_sample(sample_in_i, block_end_i));
        req_taken = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("ramped_ratio_compressor_top test failed");
      $finish;
    end
  end

  initial begin
    int        n;
    int        len;
    run_kind_e kind;
    logic [rrc_pkg::CfgW-1:0] thr, rat, gain;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // defaults: threshold at full scale, so nothing compresses
    push_request(24'd0, 1'b0);
    push_request(24'd8388607, 1'b0);
    push_request(24'h800000, 1'b1);
    push_request(24'd1, 1'b0);
    push_request(-24'sd1, 1'b1);
    wait_idle();

    // clamped ratio, zero lengths, max gain drives saturation
    write_all(24'h100000, 24'h7FFFFF, 24'd0, 24'd0, 24'd65535);
    push_request(24'd8388607, 1'b0);
    push_request(24'h800000, 1'b1);
    push_request(24'h100000, 1'b0);
    push_request(24'h100001, 1'b0);
    push_request(-24'sd1048577, 1'b1);
    push_request(-24'sd1048576, 1'b0);
    push_request(24'd0, 1'b1);
    wait_idle();

    // threshold above full scale, ratio below unity, zero gain
    write_all(24'hFFFFFF, 24'd0, 24'd65535, 24'd65535, 24'd0);
    push_request(24'd8388607, 1'b0);
    push_request(24'h800000, 1'b0);
    push_request(24'd12345, 1'b1);
    wait_idle();

    // ratio lowered below the running amount
    write_all(24'd0, 24'(rrc_pkg::MaxRatio), 24'd1, 24'd65535, 24'd4096);
    push_request(24'd1, 1'b0);
    wait_idle();
    write_reg(rrc_pkg::CFG_RATIO, 24'd131072);
    push_request(-24'sd5, 1'b0);
    push_request(24'd0, 1'b1);
    wait_idle();

    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 0) begin
        write_all(24'h200000, 24'(rrc_pkg::MaxRatio), 24'd65535, 24'd65535, 24'd65535);
      end else begin
        case ($urandom_range(0, 6))
          0: thr = '0;
          1: thr = 24'(rrc_pkg::FullQ23);
          2: thr = 24'hFFFFFF;
          3: thr = rrc_pkg::CfgW'($urandom);
          default: thr = rrc_pkg::CfgW'($urandom_range(0, 32'(rrc_pkg::FullQ23)));
        endcase
        case ($urandom_range(0, 4))
          0: rat = 24'(rrc_pkg::UnityQ16);
          1: rat = 24'(rrc_pkg::MaxRatio);
          2: rat = rrc_pkg::CfgW'($urandom);
          default: rat = rrc_pkg::CfgW'($urandom_range(32'(rrc_pkg::UnityQ16),
                                                        32'(rrc_pkg::MaxRatio)));
        endcase
        case ($urandom_range(0, 4))
          0: gain = '0;
          1: gain = 24'd4096;
          2: gain = 24'd65535;
          default: gain = rrc_pkg::CfgW'($urandom);
        endcase
        write_all(thr, rat, pick_length(), pick_length(), gain);
      end
      n = 0;
      while (n < PhaseItems) begin
        kind = run_kind_e'($urandom_range(0, 3));
        len = (kind == RUN_EDGE) ? $urandom_range(1, 3) : $urandom_range(1, 40);
        for (int k = 0; k < len; k++)
          push_request(pick_sample(kind), $urandom_range(0, 7) == 0);
        n += len;
      end
      wait_idle();
    end

    if (predicted_out.size() != 0)
      report_mismatch("results never delivered", 64'd0, 64'(predicted_out.size()));
    if (mismatch_count == 0) begin
      $display("ramped_ratio_compressor_top test passed");
    end else begin
      $display("ramped_ratio_compressor_top test failed");
    end
    $finish;
  end

endmodule
